// File: rtl/vfsm_pkg.sv
// ----------------------------------------------------------------------------
// vfsm_pkg
// Shared types, constants and helpers of the voxel fill and surface marker.
// ----------------------------------------------------------------------------
package vfsm_pkg;

   localparam int MAX_SIDE    = 32;
   localparam int COORD_W     = $clog2(MAX_SIDE);
   localparam int ADDR_W      = 2 * COORD_W;
   localparam int COL_W       = MAX_SIDE;
   localparam int SIDE_W      = COORD_W + 1;
   localparam int GRID_W      = 6;
   localparam int CNT_W       = $clog2(COL_W + 1);
   localparam int PFX_LVLS    = $clog2(COL_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int STEP_W      = 3;
   localparam int CMD_W       = 3;
   localparam int MARGIN      = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FILL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MARK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

   localparam logic [GRID_W-1:0] GRID_RESET     = GRID_W'(32);
   localparam logic [SIDE_W-1:0] MIN_MARK_SIDE  = SIDE_W'(2 * MARGIN + 1);
   localparam logic [STEP_W-1:0] MARK_LAST_STEP = STEP_W'(5);
   localparam logic [ADDR_W-1:0] SWEEP_LAST     = {ADDR_W{1'b1}};

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] col_x;
      logic [COORD_W-1:0] col_y;
      logic [COL_W-1:0]   column_bits;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] filled_bits;
      logic [COL_W-1:0] surface_bits;
      logic             bad_address;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_BAD,
      OP_CLEAR,
      OP_MARK,
      OP_WRITE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] idx;
      logic [COL_W-1:0]  bits;
   } work_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_ACCESS,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_RESP
   } eng_state_type;

   function automatic logic [COL_W-1:0] low_mask(input logic [SIDE_W-1:0] n);
      logic [COL_W:0] t;
      t = ((COL_W + 1)'(1) << n) - (COL_W + 1)'(1);
      return t[COL_W-1:0];
   endfunction

endpackage

// File: rtl/vfsm_front.sv
// ----------------------------------------------------------------------------
// vfsm_front
// Accepts requests, classifies them and builds the fill set of a column.
// ----------------------------------------------------------------------------
module vfsm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [vfsm_pkg::SIDE_W-1:0]    side,
   input  logic                           init_busy,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  vfsm_pkg::req_type              req_data,
   output logic                           q_push,
   output vfsm_pkg::work_type             q_data,
   input  logic                           q_full
);

   logic                             s1_valid_ff, s1_valid_in;
   vfsm_pkg::op_type                 s1_op_ff, s1_op_in;
   logic [vfsm_pkg::ADDR_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [vfsm_pkg::COL_W-1:0]       s1_hits_ff, s1_hits_in;
   logic                             s1_fill_ff, s1_fill_in;

   logic                             s2_valid_ff, s2_valid_in;
   vfsm_pkg::op_type                 s2_op_ff, s2_op_in;
   logic [vfsm_pkg::ADDR_W-1:0]      s2_idx_ff, s2_idx_in;
   logic [vfsm_pkg::COL_W-1:0]       s2_bits_ff, s2_bits_in;
   logic                             s2_fill_ff, s2_fill_in;

   logic                             s1_take, s2_take, accept, bad;
   logic [vfsm_pkg::COL_W-1:0]       full;
   vfsm_pkg::op_type                 op;

   logic [vfsm_pkg::CNT_W-1:0]       pc [0:vfsm_pkg::PFX_LVLS][0:vfsm_pkg::COL_W-1];
   logic [vfsm_pkg::CNT_W-1:0]       count, k_mid;
   logic [vfsm_pkg::COL_W-1:0]       mid, first, hmod, px;

   assign full    = vfsm_pkg::low_mask(side);
   assign q_push  = s2_valid_ff && !q_full;
   assign s2_take = !s2_valid_ff || q_push;
   assign s1_take = !s1_valid_ff || s2_take;
   assign req_ready = s1_take && !init_busy;
   assign accept  = req_valid && req_ready;

   assign bad = ({1'b0, req_data.col_x} >= side) || ({1'b0, req_data.col_y} >= side);

   always_comb begin
      unique case (req_data.command)
         vfsm_pkg::CMD_CLEAR: op = vfsm_pkg::OP_CLEAR;
         vfsm_pkg::CMD_MARK:  op = vfsm_pkg::OP_MARK;
         vfsm_pkg::CMD_LOAD,
         vfsm_pkg::CMD_FILL:  op = bad ? vfsm_pkg::OP_BAD : vfsm_pkg::OP_WRITE;
         vfsm_pkg::CMD_READ:  op = bad ? vfsm_pkg::OP_BAD : vfsm_pkg::OP_READ;
         default:             op = vfsm_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_idx_in   = s1_idx_ff;
      s1_hits_in  = s1_hits_ff;
      s1_fill_in  = s1_fill_ff;
      if (s1_take) begin
         s1_valid_in = accept;
         s1_op_in    = op;
         s1_idx_in   = {req_data.col_x, req_data.col_y};
         s1_hits_in  = req_data.column_bits & full;
         s1_fill_in  = (req_data.command == vfsm_pkg::CMD_FILL);
      end
   end

   // prefix hit counts
   always_comb begin
      for (int i = 0; i < vfsm_pkg::COL_W; i++) begin
         pc[0][i] = vfsm_pkg::CNT_W'(s1_hits_ff[i]);
      end
      for (int l = 0; l < vfsm_pkg::PFX_LVLS; l++) begin
         for (int i = 0; i < vfsm_pkg::COL_W; i++) begin
            if (i >= (1 << l)) begin
               pc[l+1][i] = pc[l][i] + pc[l][i - (1 << l)];
            end else begin
               pc[l+1][i] = pc[l][i];
            end
         end
      end
   end

   assign count = pc[vfsm_pkg::PFX_LVLS][vfsm_pkg::COL_W-1];
   assign k_mid = (count >> 1) + vfsm_pkg::CNT_W'(1);
   assign first = s1_hits_ff & (~s1_hits_ff + vfsm_pkg::COL_W'(1));

   always_comb begin
      for (int i = 0; i < vfsm_pkg::COL_W; i++) begin
         mid[i] = s1_hits_ff[i] && (pc[vfsm_pkg::PFX_LVLS][i] == k_mid);
      end
   end

   always_comb begin
      priority if (count == vfsm_pkg::CNT_W'(1)) begin
         hmod = s1_hits_ff | ((first << 1) & full);
      end else if (count[0] && count >= vfsm_pkg::CNT_W'(3)) begin
         hmod = s1_hits_ff & ~mid;
      end else begin
         hmod = s1_hits_ff;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_op_in    = s2_op_ff;
      s2_idx_in   = s2_idx_ff;
      s2_bits_in  = s2_bits_ff;
      s2_fill_in  = s2_fill_ff;
      if (s2_take) begin
         s2_valid_in = s1_valid_ff;
         s2_op_in    = s1_op_ff;
         s2_idx_in   = s1_idx_ff;
         s2_bits_in  = s1_fill_ff ? hmod : s1_hits_ff;
         s2_fill_in  = s1_fill_ff;
      end
   end

   // inside flag as a prefix parity
   always_comb begin
      px = s2_bits_ff;
      for (int l = 0; l < vfsm_pkg::PFX_LVLS; l++) begin
         px = px ^ (px << (1 << l));
      end
   end

   assign q_data.op   = s2_op_ff;
   assign q_data.idx  = s2_idx_ff;
   assign q_data.bits = s2_fill_ff ? ((s2_bits_ff | px) & full) : s2_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_idx_ff  <= s1_idx_in;
      s1_hits_ff <= s1_hits_in;
      s1_fill_ff <= s1_fill_in;
      s2_op_ff   <= s2_op_in;
      s2_idx_ff  <= s2_idx_in;
      s2_bits_ff <= s2_bits_in;
      s2_fill_ff <= s2_fill_in;
   end

endmodule

// File: rtl/vfsm_queue.sv
// ----------------------------------------------------------------------------
// vfsm_queue
// Short work queue between the classifying front and the grid engine.
// ----------------------------------------------------------------------------
module vfsm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vfsm_pkg::work_type  push_data,
   output logic                full,
   input  logic                pop,
   output vfsm_pkg::work_type  head,
   output logic                empty
);

   vfsm_pkg::work_type            entries_ff [vfsm_pkg::QUEUE_DEPTH];
   logic [vfsm_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [vfsm_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [vfsm_pkg::QPTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (vfsm_pkg::QPTR_W + 1)'(vfsm_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + vfsm_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + vfsm_pkg::QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (vfsm_pkg::QPTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (vfsm_pkg::QPTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/vfsm_engine.sv
// ----------------------------------------------------------------------------
// vfsm_engine
// Carries out queued work against the filled and surface column memories.
// ----------------------------------------------------------------------------
module vfsm_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vfsm_pkg::SIDE_W-1:0]   side,
   input  logic                          q_empty,
   input  vfsm_pkg::work_type            q_head,
   output logic                          q_pop,
   output logic                          init_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vfsm_pkg::rsp_type             rsp_data
);

   logic [vfsm_pkg::COL_W-1:0]    filled_mem  [1 << vfsm_pkg::ADDR_W];
   logic [vfsm_pkg::COL_W-1:0]    surface_mem [1 << vfsm_pkg::ADDR_W];
   logic [vfsm_pkg::COL_W-1:0]    filled_rd_ff, surface_rd_ff;

   vfsm_pkg::eng_state_type       state_ff, state_in;
   vfsm_pkg::op_type              op_ff, op_in;
   logic [vfsm_pkg::ADDR_W-1:0]   idx_ff, idx_in;
   logic [vfsm_pkg::COL_W-1:0]    bits_ff, bits_in;
   logic [vfsm_pkg::ADDR_W-1:0]   sweep_ff, sweep_in;
   logic [vfsm_pkg::COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [vfsm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [vfsm_pkg::COL_W-1:0]    here_ff, here_in, empty_ff, empty_in;
   vfsm_pkg::rsp_type             res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   vfsm_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                          f_we, f_re, s_we, s_re;
   logic [vfsm_pkg::ADDR_W-1:0]   f_waddr, f_raddr, s_waddr, s_raddr;
   logic [vfsm_pkg::COL_W-1:0]    f_wdata, s_wdata;
   logic                          emit, rsp_free, scan_done;
   vfsm_pkg::rsp_type             res_val;
   logic [vfsm_pkg::COL_W-1:0]    full, interior, empty_diag;
   logic [vfsm_pkg::COORD_W-1:0]  lim, xm, xp, ym, yp;

   assign full       = vfsm_pkg::low_mask(side);
   assign interior   = vfsm_pkg::low_mask(side - vfsm_pkg::SIDE_W'(vfsm_pkg::MARGIN))
                       & ~vfsm_pkg::low_mask(vfsm_pkg::SIDE_W'(vfsm_pkg::MARGIN));
   assign empty_diag = (empty_ff << 1) | (empty_ff >> 1);
   assign lim        = vfsm_pkg::COORD_W'(side - vfsm_pkg::SIDE_W'(vfsm_pkg::MARGIN + 1));
   assign xm         = x_ff - vfsm_pkg::COORD_W'(1);
   assign xp         = x_ff + vfsm_pkg::COORD_W'(1);
   assign ym         = y_ff - vfsm_pkg::COORD_W'(1);
   assign yp         = y_ff + vfsm_pkg::COORD_W'(1);
   assign scan_done  = (x_ff == lim) && (y_ff == lim);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign init_busy  = (state_ff == vfsm_pkg::ST_INIT);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      bits_in      = bits_ff;
      sweep_in     = sweep_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      step_in      = step_ff;
      here_in      = here_ff;
      empty_in     = empty_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      f_we         = 1'b0;
      f_waddr      = sweep_ff;
      f_wdata      = '0;
      f_re         = 1'b0;
      f_raddr      = q_head.idx;
      s_we         = 1'b0;
      s_waddr      = sweep_ff;
      s_wdata      = '0;
      s_re         = 1'b0;
      s_raddr      = q_head.idx;
      emit         = 1'b0;
      res_val      = '0;

      unique case (state_ff)
         vfsm_pkg::ST_INIT: begin
            f_we     = 1'b1;
            s_we     = 1'b1;
            sweep_in = sweep_ff + vfsm_pkg::ADDR_W'(1);
            if (sweep_ff == vfsm_pkg::SWEEP_LAST) begin
               state_in = vfsm_pkg::ST_IDLE;
            end
         end
         vfsm_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               f_re    = 1'b1;
               s_re    = 1'b1;
               op_in   = q_head.op;
               idx_in  = q_head.idx;
               bits_in = q_head.bits;
               unique case (q_head.op)
                  vfsm_pkg::OP_NOP: emit = 1'b1;
                  vfsm_pkg::OP_BAD: begin
                     emit                = 1'b1;
                     res_val.bad_address = 1'b1;
                  end
                  vfsm_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = vfsm_pkg::ST_CLEAR;
                  end
                  vfsm_pkg::OP_MARK: begin
                     if (side < vfsm_pkg::MIN_MARK_SIDE) begin
                        emit = 1'b1;
                     end else begin
                        x_in     = vfsm_pkg::COORD_W'(vfsm_pkg::MARGIN);
                        y_in     = vfsm_pkg::COORD_W'(vfsm_pkg::MARGIN);
                        step_in  = '0;
                        empty_in = '0;
                        state_in = vfsm_pkg::ST_MARK_RD;
                     end
                  end
                  vfsm_pkg::OP_WRITE,
                  vfsm_pkg::OP_READ: state_in = vfsm_pkg::ST_ACCESS;
                  default: emit = 1'b1;
               endcase
            end
         end
         vfsm_pkg::ST_CLEAR: begin
            f_we     = 1'b1;
            s_we     = 1'b1;
            sweep_in = sweep_ff + vfsm_pkg::ADDR_W'(1);
            if (sweep_ff == vfsm_pkg::SWEEP_LAST) begin
               emit = 1'b1;
            end
         end
         vfsm_pkg::ST_ACCESS: begin
            emit = 1'b1;
            if (op_ff == vfsm_pkg::OP_WRITE) begin
               f_we    = 1'b1;
               f_waddr = idx_ff;
               f_wdata = filled_rd_ff | bits_ff;
               s_we    = 1'b1;
               s_waddr = idx_ff;
               s_wdata = surface_rd_ff & ~bits_ff;
            end else begin
               res_val.filled_bits  = filled_rd_ff;
               res_val.surface_bits = surface_rd_ff;
            end
         end
         vfsm_pkg::ST_MARK_RD: begin
            unique case (step_ff)
               3'd0:    f_raddr = {x_ff, y_ff};
               3'd1:    f_raddr = {xm, ym};
               3'd2:    f_raddr = {xm, yp};
               3'd3:    f_raddr = {xp, ym};
               3'd4:    f_raddr = {xp, yp};
               default: f_raddr = {x_ff, y_ff};
            endcase
            f_re    = (step_ff != vfsm_pkg::MARK_LAST_STEP);
            s_re    = (step_ff == '0);
            s_raddr = {x_ff, y_ff};
            if (step_ff == vfsm_pkg::STEP_W'(1)) begin
               here_in = filled_rd_ff;
            end else if (step_ff != '0) begin
               empty_in = empty_ff | (~filled_rd_ff & full);
            end
            step_in = step_ff + vfsm_pkg::STEP_W'(1);
            if (step_ff == vfsm_pkg::MARK_LAST_STEP) begin
               state_in = vfsm_pkg::ST_MARK_WR;
            end
         end
         vfsm_pkg::ST_MARK_WR: begin
            s_we     = 1'b1;
            s_waddr  = {x_ff, y_ff};
            s_wdata  = surface_rd_ff | (here_ff & interior & empty_diag);
            step_in  = '0;
            empty_in = '0;
            if (y_ff == lim) begin
               y_in = vfsm_pkg::COORD_W'(vfsm_pkg::MARGIN);
               x_in = xp;
            end else begin
               y_in = yp;
            end
            if (scan_done) begin
               emit = 1'b1;
            end else begin
               state_in = vfsm_pkg::ST_MARK_RD;
            end
         end
         vfsm_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = vfsm_pkg::ST_IDLE;
            end
         end
         default: state_in = vfsm_pkg::ST_IDLE;
      endcase

      if (emit) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_val;
            state_in     = vfsm_pkg::ST_IDLE;
         end else begin
            res_in   = res_val;
            state_in = vfsm_pkg::ST_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfsm_pkg::ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      bits_ff     <= bits_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      step_ff     <= step_in;
      here_ff     <= here_in;
      empty_ff    <= empty_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         filled_mem[f_waddr] <= f_wdata;
      end
      if (f_re) begin
         filled_rd_ff <= filled_mem[f_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         surface_mem[s_waddr] <= s_wdata;
      end
      if (s_re) begin
         surface_rd_ff <= surface_mem[s_raddr];
      end
   end

endmodule

// File: rtl/voxel_fill_and_surface_marker_unit.sv
// ----------------------------------------------------------------------------
// voxel_fill_and_surface_marker_unit
// Voxel grid of 32 x 32 columns with column fill and surface marking.
// ----------------------------------------------------------------------------
// Usage: one request transaction on req_* gives exactly one response
// transaction on rsp_*, in order. csr_wr_en/csr_wr_data set the grid side
// and must be written by the user only while the unit is idle; the unit
// does not enforce this. A request passes two front stages and a 4-entry
// queue, then the engine. The engine pops load, fill and read when idle,
// then answers them from its access state, where load and fill do a
// read-modify-write of the filled and surface column memories; it answers
// bad-address and unknown commands when idle and pops no new column before
// the last is answered. Clear sweeps all 1024 columns, one per cycle. Mark
// visits each of the (n-4)^2 interior columns for side n with five reads
// of the filled memory and one read and one write of the surface memory.
// After reset the memories are cleared in a pass over all 1024 columns;
// req_ready stays low during it. A stalled response is held in the output
// register; the queue and front stages keep filling until req_ready drops.
// ----------------------------------------------------------------------------
module voxel_fill_and_surface_marker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  vfsm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vfsm_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [vfsm_pkg::GRID_W-1:0]   csr_wr_data
);

   logic [vfsm_pkg::GRID_W-1:0]   grid_ff, grid_in;
   logic [vfsm_pkg::SIDE_W-1:0]   side;
   logic                          init_busy, q_push, q_full, q_pop, q_empty;
   vfsm_pkg::work_type            q_data, q_head;

   assign grid_in = csr_wr_en ? csr_wr_data : grid_ff;
   assign side    = (grid_ff > vfsm_pkg::GRID_W'(vfsm_pkg::MAX_SIDE))
                    ? vfsm_pkg::SIDE_W'(vfsm_pkg::MAX_SIDE)
                    : vfsm_pkg::SIDE_W'(grid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= vfsm_pkg::GRID_RESET;
      end else begin
         grid_ff <= grid_in;
      end
   end

   vfsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .side      (side),
      .init_busy (init_busy),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_data),
      .q_full    (q_full)
   );

   vfsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   vfsm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .side      (side),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_reset_starts_init: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> init_busy)
      else $error("clearing pass not running after reset");

   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("engine popped an empty queue");

   a_bad_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_address)
         |-> ((rsp_data.filled_bits == '0) && (rsp_data.surface_bits == '0)))
      else $error("bad-address response carries column data");

endmodule
